### design/fmpm_pkg.sv
// Shared types and constants for the farthest marker pair midpoint block.
// No dependencies; used by every module in the design folder but fmpm_queue.
`default_nettype none

package fmpm_pkg;

  localparam int MaxMarkers    = 16;  // default store depth
  localparam int CoordW        = 16;  // Q12.4 coordinate width
  localparam int CenterW       = 12;  // whole-pixel center width
  localparam int CenterShift   = 5;   // drop 4 fraction bits and halve the sum
  localparam int MinRecognized = 2;   // need strictly more than this many
  localparam int SumW          = CoordW + 1;
  localparam int SqW           = 2 * CoordW;
  localparam int DistW         = SqW + 1;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              rec;
  } point_t;

  typedef enum logic [2:0] {
    BackIdle,
    BackNextI,
    BackLoadI,
    BackScan,
    BackDrain
  } back_state_e;

endpackage

`default_nettype wire

### design/fmpm_front.sv
// Front end: takes marker transactions, writes the point store, keeps frame counts
// and pushes one search job per frame. Depends on fmpm_pkg.
`default_nettype none

module fmpm_front #(
  parameter int MaxMarkers = fmpm_pkg::MaxMarkers,
  localparam int CntW  = $clog2(MaxMarkers + 1),
  localparam int AddrW = $clog2(MaxMarkers),
  localparam int JobW  = 2 * CntW + 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        busy_i,
  input  wire logic [fmpm_pkg::CoordW-1:0] pos_x_i,
  input  wire logic [fmpm_pkg::CoordW-1:0] pos_y_i,
  input  wire logic                        recognized_i,
  input  wire logic                        last_marker_i,
  output logic                             push_o,
  output logic [JobW-1:0]                  job_o,
  input  wire logic                        rd_en_i,
  input  wire logic [AddrW-1:0]            rd_addr_i,
  output fmpm_pkg::point_t                 rd_data_o
);

  fmpm_pkg::point_t mem [MaxMarkers];
  fmpm_pkg::point_t wr_point;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rc_q, rc_d;
  logic            ovf_q, ovf_d;
  logic            accept;
  logic            room;
  logic            wr_en;

  assign accept = start_i & ~busy_i;
  assign room   = cnt_q < CntW'(MaxMarkers);
  assign wr_en  = accept & room;

  assign wr_point.x   = pos_x_i;
  assign wr_point.y   = pos_y_i;
  assign wr_point.rec = recognized_i;

  always_comb begin
    cnt_d = cnt_q;
    rc_d  = rc_q;
    ovf_d = ovf_q;
    if (room) begin
      cnt_d = cnt_q + CntW'(1);
      rc_d  = rc_q + CntW'(recognized_i);
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_o = accept & last_marker_i;
  assign job_o  = {ovf_d, rc_d, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rc_q  <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      if (last_marker_i) begin
        // frame closes: counts travel with the job
        cnt_q <= '0;
        rc_q  <= '0;
        ovf_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        rc_q  <= rc_d;
        ovf_q <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AddrW-1:0]] <= wr_point;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### design/fmpm_queue.sv
// Two-entry job queue between the front end and the search engine.
// Depends on nothing but its data width parameter.
`default_nettype none

module fmpm_queue #(
  parameter int DataW = 11
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] data_i,
  input  wire logic             pop_i,
  output logic [DataW-1:0]      data_o,
  output logic                  valid_o
);

  logic [DataW-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       fill_q;

  assign valid_o = fill_q != 2'd0;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### design/fmpm_back.sv
// Search engine: walks all recognized pairs j < i through the store read port,
// squared distance in a three-stage pipe, keeps the first strict maximum.
// Depends on fmpm_pkg.
`default_nettype none

module fmpm_back #(
  parameter int MaxMarkers = fmpm_pkg::MaxMarkers,
  localparam int CntW  = $clog2(MaxMarkers + 1),
  localparam int AddrW = $clog2(MaxMarkers),
  localparam int JobW  = 2 * CntW + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         job_valid_i,
  input  wire logic [JobW-1:0]              job_i,
  output logic                              pop_o,
  output logic                              rd_en_o,
  output logic [AddrW-1:0]                  rd_addr_o,
  input  wire fmpm_pkg::point_t             rd_data_i,
  output logic                              active_o,
  output logic                              done_o,
  output logic [fmpm_pkg::CenterW-1:0]      center_x_o,
  output logic [fmpm_pkg::CenterW-1:0]      center_y_o,
  output logic                              found_o,
  output logic                              overflowed_o
);

  localparam int CoordW = fmpm_pkg::CoordW;
  localparam int SumW   = fmpm_pkg::SumW;
  localparam int SqW    = fmpm_pkg::SqW;
  localparam int DistW  = fmpm_pkg::DistW;

  fmpm_pkg::back_state_e state_q, state_d;

  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] n_q, rc_q;
  logic            ovf_q;
  logic            load_job, ld_i, issue_j, emit;

  logic [CoordW-1:0] xi_q, yi_q;

  // stage 1: store data arriving
  logic              s1_v_q;
  logic [CoordW-1:0] s1_xi_q, s1_yi_q;
  // stage 2: deltas and sums
  logic              s2_v_q;
  logic [CoordW-1:0] s2_dx_q, s2_dy_q;
  logic [SumW-1:0]   s2_sx_q, s2_sy_q;
  // stage 3: squares
  logic              s3_v_q;
  logic [SqW-1:0]    s3_dxx_q, s3_dyy_q;
  logic [SumW-1:0]   s3_sx_q, s3_sy_q;

  logic [DistW-1:0]  sq_sum;
  logic [DistW-1:0]  best_q;
  logic [SumW-1:0]   bsx_q, bsy_q;
  logic              have_q;
  logic              hit;
  logic              found_n;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    rd_en_o   = 1'b0;
    rd_addr_o = i_q[AddrW-1:0];
    pop_o     = 1'b0;
    load_job  = 1'b0;
    ld_i      = 1'b0;
    issue_j   = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      fmpm_pkg::BackIdle: begin
        if (job_valid_i) begin
          pop_o    = 1'b1;
          load_job = 1'b1;
          i_d      = CntW'(1);
          state_d  = fmpm_pkg::BackNextI;
        end
      end
      fmpm_pkg::BackNextI: begin
        if (i_q >= n_q) begin
          state_d = fmpm_pkg::BackDrain;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = i_q[AddrW-1:0];
          state_d   = fmpm_pkg::BackLoadI;
        end
      end
      fmpm_pkg::BackLoadI: begin
        ld_i = 1'b1;
        if (rd_data_i.rec) begin
          j_d     = '0;
          state_d = fmpm_pkg::BackScan;
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = fmpm_pkg::BackNextI;
        end
      end
      fmpm_pkg::BackScan: begin
        rd_en_o   = 1'b1;
        rd_addr_o = j_q[AddrW-1:0];
        issue_j   = 1'b1;
        j_d       = j_q + CntW'(1);
        if (j_q == i_q - CntW'(1)) begin
          i_d     = i_q + CntW'(1);
          state_d = fmpm_pkg::BackNextI;
        end
      end
      fmpm_pkg::BackDrain: begin
        if (!s1_v_q && !s2_v_q && !s3_v_q) begin
          emit    = 1'b1;
          state_d = fmpm_pkg::BackIdle;
        end
      end
      default: state_d = fmpm_pkg::BackIdle;
    endcase
  end

  assign active_o = state_q != fmpm_pkg::BackIdle;

  assign sq_sum  = DistW'(s3_dxx_q) + DistW'(s3_dyy_q);
  assign hit     = s3_v_q && (sq_sum > best_q);
  assign found_n = (rc_q > CntW'(fmpm_pkg::MinRecognized)) && have_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmpm_pkg::BackIdle;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= issue_j;
      s2_v_q  <= s1_v_q & rd_data_i.rec;
      s3_v_q  <= s2_v_q;
      done_o  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    if (load_job) begin
      n_q    <= job_i[CntW-1:0];
      rc_q   <= job_i[2*CntW-1:CntW];
      ovf_q  <= job_i[2*CntW];
      best_q <= '0;
      have_q <= 1'b0;
    end else if (hit) begin
      best_q <= sq_sum;
      bsx_q  <= s3_sx_q;
      bsy_q  <= s3_sy_q;
      have_q <= 1'b1;
    end
    if (ld_i) begin
      xi_q <= rd_data_i.x;
      yi_q <= rd_data_i.y;
    end
    // outer point travels with each read so a new i cannot disturb pairs in flight
    s1_xi_q <= xi_q;
    s1_yi_q <= yi_q;

    s2_dx_q <= (s1_xi_q >= rd_data_i.x) ? s1_xi_q - rd_data_i.x : rd_data_i.x - s1_xi_q;
    s2_dy_q <= (s1_yi_q >= rd_data_i.y) ? s1_yi_q - rd_data_i.y : rd_data_i.y - s1_yi_q;
    s2_sx_q <= SumW'(s1_xi_q) + SumW'(rd_data_i.x);
    s2_sy_q <= SumW'(s1_yi_q) + SumW'(rd_data_i.y);

    s3_dxx_q <= SqW'(s2_dx_q) * SqW'(s2_dx_q);
    s3_dyy_q <= SqW'(s2_dy_q) * SqW'(s2_dy_q);
    s3_sx_q  <= s2_sx_q;
    s3_sy_q  <= s2_sy_q;

    if (emit) begin
      found_o      <= found_n;
      overflowed_o <= ovf_q;
      center_x_o   <= found_n ? bsx_q[fmpm_pkg::CenterShift +: fmpm_pkg::CenterW] : '0;
      center_y_o   <= found_n ? bsy_q[fmpm_pkg::CenterShift +: fmpm_pkg::CenterW] : '0;
    end
  end

endmodule

`default_nettype wire

### design/farthest_marker_pair_midpoint.sv
// Top level of the farthest marker pair midpoint block: front end, job queue,
// search engine. Depends on fmpm_pkg, fmpm_front, fmpm_queue, fmpm_back.
//
//   channel   direction  handshake            payload
//   marker    in         start & !busy        pos_x_i, pos_y_i, recognized_i, last_marker_i
//   result    out        done_o (one cycle)   center_x_o, center_y_o, found_o, overflowed_o
//
// A marker without last_marker is taken whenever busy is low; markers stream back to back.
// A last marker closes the frame: busy stays high while the engine walks the
// pairs, one store read per cycle, until the result is emitted.
// done_o pulses once per frame.
// Reset is asynchronous, active low; the store holds no reset value.
// The receiver cannot stall; only the input side waits, on busy.
`default_nettype none

module farthest_marker_pair_midpoint #(
  parameter int MaxMarkers = fmpm_pkg::MaxMarkers
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [fmpm_pkg::CoordW-1:0]  pos_x_i,
  input  wire logic [fmpm_pkg::CoordW-1:0]  pos_y_i,
  input  wire logic                         recognized_i,
  input  wire logic                         last_marker_i,
  output logic                              done_o,
  output logic [fmpm_pkg::CenterW-1:0]      center_x_o,
  output logic [fmpm_pkg::CenterW-1:0]      center_y_o,
  output logic                              found_o,
  output logic                              overflowed_o
);

  localparam int CntW  = $clog2(MaxMarkers + 1);
  localparam int AddrW = $clog2(MaxMarkers);
  localparam int JobW  = 2 * CntW + 1;

  logic             push;
  logic [JobW-1:0]  job_in, job_out;
  logic             job_valid;
  logic             pop;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  fmpm_pkg::point_t rd_data;
  logic             back_active;

  // the store is shared, so a new frame waits until the previous one is searched
  assign busy = job_valid | back_active;

  fmpm_front #(
    .MaxMarkers(MaxMarkers)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .recognized_i (recognized_i),
    .last_marker_i(last_marker_i),
    .push_o       (push),
    .job_o        (job_in),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data)
  );

  fmpm_queue #(
    .DataW(JobW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .valid_o(job_valid)
  );

  fmpm_back #(
    .MaxMarkers(MaxMarkers)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .active_o    (back_active),
    .done_o      (done_o),
    .center_x_o  (center_x_o),
    .center_y_o  (center_y_o),
    .found_o     (found_o),
    .overflowed_o(overflowed_o)
  );

endmodule

`default_nettype wire
